// ----- hdl/pq_pkg.sv -----
package pq_pkg;

   localparam int ITEM_W   = 8;
   localparam int PRIO_W   = 15;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 4;

   typedef logic [ITEM_W-1:0]   item_type;
   typedef logic [PRIO_W-1:0]   prio_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [OCC_W-1:0]    occ_type;

   // operation codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // result status codes
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   // ASCII '0', returned when no item comes out
   localparam item_type ITEM_NONE = 8'd48;

endpackage

// ----- hdl/pq_req_if.sv -----
interface pq_req_if import pq_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     cmd;
   item_type item_in;
   prio_type priority_req;

   modport source (output valid, output cmd, output item_in, output priority_req,
                   input ready);
   modport sink   (input valid, input cmd, input item_in, input priority_req,
                   output ready);
endinterface

// ----- hdl/pq_rsp_if.sv -----
interface pq_rsp_if import pq_pkg::*; ();
   logic       valid;
   logic       ready;
   item_type   item_out;
   status_type status;
   occ_type    occupancy;

   modport source (output valid, output item_out, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input item_out, input status, input occupancy,
                   output ready);
endinterface

// ----- hdl/pq_ram.sv -----
module pq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/priority_queue_insert_extract_max_top.sv -----
// Bounded priority queue of byte items with 15-bit priorities, DEPTH entries.
// req_ch carries one word per operation: cmd (insert or remove), item_in and
// priority_req. rsp_ch returns exactly one word per request: item_out, status
// and occupancy (entries held afterwards, low 4 bits).
// Insert appends at the tail of the entry RAM; a full queue rejects it with
// the full status. Remove scans the entries for the largest priority (earliest
// entry wins a tie), returns its item and moves every later entry down one
// place, so insertion order is kept. Remove on an empty queue returns '0'
// with the empty status.
// Responses: insert, rejected insert and empty remove show their response in
// the cycle after acceptance. A remove reads every held entry in a scan, then
// moves each entry after the chosen one down one place, then loads the
// response once the output register is free; the scan and the moves go through
// the single read port of the entry RAM, one entry per cycle.
// Throughput: inserts and empty removes can be taken every cycle while
// rsp_ch.ready stays high; a remove holds req_ch.ready low until it responds.
// Reset (synchronous, active high) empties the queue and drops any pending
// response; entry contents are not cleared. A stalled response is held in the
// output register; the next request is taken as soon as that register frees.
module priority_queue_insert_extract_max_top import pq_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic      clock,
   input  logic      reset,
   pq_req_if.sink    req_ch,
   pq_rsp_if.source  rsp_ch
);

   localparam int IW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = ITEM_W + PRIO_W;
   localparam logic [IW-1:0] DEPTH_CNT = IW'(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [IW-1:0]    count_ff, count_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    best_idx_ff, best_idx_in;
   prio_type         best_prio_ff, best_prio_in;
   item_type         best_item_ff, best_item_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_addr_ff, pend_addr_in;

   logic             rsp_valid_ff, rsp_valid_in;
   item_type         rsp_item_ff, rsp_item_in;
   status_type       rsp_status_ff, rsp_status_in;
   occ_type          rsp_occ_ff, rsp_occ_in;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [EW-1:0]    ram_wr_data;
   logic [AW-1:0]    ram_rd_addr;
   logic [EW-1:0]    ram_rd_data;
   item_type         rd_item;
   prio_type         rd_prio;

   logic             rsp_free;
   logic             accept;
   logic             take;
   logic [IW-1:0]    count_inc;
   logic [IW-1:0]    count_dec;
   logic [IW-1:0]    idx_dec;

   // item and priority share one RAM word
   pq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_item = ram_rd_data[EW-1:PRIO_W];
   assign rd_prio = ram_rd_data[PRIO_W-1:0];

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign count_inc = count_ff + 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign idx_dec   = idx_ff - 1'b1;

   // first entry is always taken; later ones only on a strictly larger priority
   assign take = (idx_ff == IW'(1)) || (rd_prio > best_prio_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      best_item_in  = best_item_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_item_in   = rsp_item_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_addr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.cmd == CMD_INSERT) begin
                  rsp_valid_in = 1'b1;
                  rsp_item_in  = ITEM_NONE;
                  if (count_ff < DEPTH_CNT) begin
                     // append at the tail
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = count_ff[AW-1:0];
                     ram_wr_data   = {req_ch.item_in, req_ch.priority_req};
                     count_in      = count_inc;
                     rsp_status_in = STATUS_OK;
                     rsp_occ_in    = OCC_W'(count_inc);
                  end else begin
                     rsp_status_in = STATUS_FULL;
                     rsp_occ_in    = OCC_W'(count_ff);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_item_in   = ITEM_NONE;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_occ_in    = '0;
               end else begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue one read per cycle, compare the word read in the previous cycle
            if (idx_ff < count_ff) begin
               ram_rd_addr = idx_ff[AW-1:0];
               idx_in      = idx_ff + 1'b1;
            end
            if (idx_ff != '0 && take) begin
               best_idx_in  = idx_dec;
               best_prio_in = rd_prio;
               best_item_in = rd_item;
            end
            if (idx_ff == count_ff) begin
               idx_in   = best_idx_in + 1'b1;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // read entry k+1, write it back at k on the next cycle
            pend_in = 1'b0;
            if (idx_ff < count_ff) begin
               ram_rd_addr  = idx_ff[AW-1:0];
               idx_in       = idx_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = idx_dec[AW-1:0];
            end
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pend_addr_ff;
               ram_wr_data = ram_rd_data;
            end
            if (!(idx_ff < count_ff) && !pend_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = best_item_ff;
               rsp_status_in = STATUS_OK;
               rsp_occ_in    = OCC_W'(count_dec);
               count_in      = count_dec;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      best_item_ff  <= best_item_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.item_out  = rsp_item_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.occupancy = rsp_occ_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count above depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_FULL) |-> count_ff == DEPTH_CNT)
      else $error("full status with free entries");

   a_move_in_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (IW'(pend_addr_ff) + 1'b1) < count_ff)
      else $error("entry move outside held entries");

   a_remove_drops_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> count_ff == $past(count_dec))
      else $error("remove did not drop exactly one entry");
`endif

endmodule
